// ===== hw/rtl/qnl_pkg.sv =====
// Shared widths, constants and sideband types for the quaternion blend pipeline.
package qnl_pkg;

    localparam int NLANE = 4;          // quaternion components
    localparam int CW    = 16;         // Q1.15 component width
    localparam int TW    = 17;         // blend factor width
    localparam int PW    = 32;         // component product width
    localparam int DTW   = 34;         // dot product width
    localparam int MW    = 33;         // blended component width
    localparam int HW    = 31;         // halved magnitude width
    localparam int QW2   = 2 * HW;     // squared magnitude width
    localparam int SW    = 63;         // sum of squares width
    localparam int LW    = 32;         // square root width
    localparam int NSQRT = (SW + 1) / 2;
    localparam int NDIV  = CW;         // quotient bits
    localparam int NW    = HW + CW;    // dividend width
    localparam int DW    = LW + 1;     // divisor width
    localparam int RW    = DW + NDIV;  // shifted divisor width

    localparam logic [TW-1:0] ONE_T   = 17'd65536;
    localparam logic [CW-1:0] MAX_POS = 16'd32767;
    localparam logic [CW-1:0] MAX_NEG = 16'd32768;

    // Items carried alongside the square root.
    typedef struct packed {
        logic [NLANE-1:0][HW-1:0] h;
        logic [NLANE-1:0]         neg;
        logic                     degen;
    } side_t;

    // Items carried alongside the divider.
    typedef struct packed {
        logic [NLANE-1:0] neg;
        logic             degen;
    } tag_t;

endpackage

// ===== hw/rtl/qnl_front.sv =====
// Front stages: dot product, shortest-arc blend, magnitudes and sum of squares.
module qnl_front
    import qnl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] a [NLANE],
    input  logic signed [CW-1:0] b [NLANE],
    input  logic        [TW-1:0] t,
    output logic                 out_valid,
    output side_t                out_side,
    output logic        [SW-1:0] out_s
);

    logic [5:0] v_reg;

    logic signed [CW-1:0]  a1_reg [NLANE];
    logic signed [CW-1:0]  b1_reg [NLANE];
    logic        [TW-1:0]  t1_reg;
    logic signed [PW-1:0]  p1_reg [NLANE];
    logic signed [CW-1:0]  a2_reg [NLANE];
    logic signed [CW-1:0]  b2_reg [NLANE];
    logic        [TW-1:0]  t2_reg;
    logic signed [DTW-1:0] dot2_reg;
    logic signed [MW-1:0]  m3_reg [NLANE];
    logic        [HW-1:0]  h4_reg [NLANE];
    logic        [NLANE-1:0] neg4_reg;
    logic        [HW-1:0]  h5_reg [NLANE];
    logic        [NLANE-1:0] neg5_reg;
    logic        [QW2-1:0] sq5_reg [NLANE];
    logic        [HW-1:0]  h6_reg [NLANE];
    logic        [NLANE-1:0] neg6_reg;
    logic        [SW-1:0]  s6_reg;

    logic        [TW-1:0]  t_sat;
    logic signed [DTW-1:0] dot_next;
    logic signed [TW-1:0]  bb      [NLANE];
    logic signed [MW-1:0]  m_next  [NLANE];
    logic        [MW-1:0]  mag     [NLANE];
    logic        [SW-1:0]  s_next;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Blend weights, shortest-arc sign choice, magnitudes and the sum of their squares.
    always_comb
    begin
        t_sat    = (t > ONE_T) ? ONE_T : t;
        dot_next = DTW'(p1_reg[0]) + DTW'(p1_reg[1]) + DTW'(p1_reg[2]) + DTW'(p1_reg[3]);
        s_next   = SW'(sq5_reg[0]) + SW'(sq5_reg[1]) + SW'(sq5_reg[2]) + SW'(sq5_reg[3]);
        for (int i = 0; i < NLANE; i++)
        begin
            bb[i]     = dot2_reg[DTW-1] ? -TW'(b2_reg[i]) : TW'(b2_reg[i]);
            m_next[i] = $signed({1'b0, ONE_T - t2_reg}) * MW'(a2_reg[i])
                      + $signed({1'b0, t2_reg}) * MW'(bb[i]);
            mag[i]    = m3_reg[i][MW-1] ? MW'(-m3_reg[i]) : MW'(m3_reg[i]);
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t_sat;
            t2_reg   <= t1_reg;
            dot2_reg <= dot_next;
            s6_reg   <= s_next;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            for (int i = 0; i < NLANE; i++)
            begin
                a1_reg[i]   <= a[i];
                b1_reg[i]   <= b[i];
                p1_reg[i]   <= a[i] * b[i];
                a2_reg[i]   <= a1_reg[i];
                b2_reg[i]   <= b1_reg[i];
                m3_reg[i]   <= m_next[i];
                h4_reg[i]   <= HW'((mag[i] + 1'b1) >> 1);
                neg4_reg[i] <= m3_reg[i][MW-1];
                h5_reg[i]   <= h4_reg[i];
                sq5_reg[i]  <= QW2'(h4_reg[i]) * QW2'(h4_reg[i]);
                h6_reg[i]   <= h5_reg[i];
            end
        end
    end

    // Hand the sum and its sideband to the square root.
    always_comb
    begin
        out_valid      = v_reg[5];
        out_s          = s6_reg;
        out_side.neg   = neg6_reg;
        out_side.degen = (s6_reg == '0);
        for (int i = 0; i < NLANE; i++)
        begin
            out_side.h[i] = h6_reg[i];
        end
    end

endmodule

// ===== hw/rtl/qnl_sqrt.sv =====
// Integer square root, one result bit per pipeline stage.
module qnl_sqrt
    import qnl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_s,
    input  side_t         in_side,
    output logic          out_valid,
    output logic [LW-1:0] out_len,
    output side_t         out_side
);

    logic [NSQRT-1:0] v_reg;
    logic [SW-1:0]    s_reg    [NSQRT];
    logic [SW-1:0]    r_reg    [NSQRT];
    side_t            side_reg [NSQRT];
    logic [SW-1:0]    s_next   [NSQRT];
    logic [SW-1:0]    r_next   [NSQRT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSQRT-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < NSQRT; k++)
    begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 1 - 2 * k);
        logic [SW-1:0] s_in;
        logic [SW-1:0] r_in;
        logic [SW-1:0] trial;

        // Try to place the current root bit.
        always_comb
        begin
            if (k == 0)
            begin
                s_in = in_s;
                r_in = '0;
            end
            else
            begin
                s_in = s_reg[(k == 0) ? 0 : k - 1];
                r_in = r_reg[(k == 0) ? 0 : k - 1];
            end
            trial = r_in + BIT;
            if (s_in >= trial)
            begin
                s_next[k] = s_in - trial;
                r_next[k] = (r_in >> 1) + BIT;
            end
            else
            begin
                s_next[k] = s_in;
                r_next[k] = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k]    <= s_next[k];
                r_reg[k]    <= r_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = v_reg[NSQRT-1];
    assign out_len   = r_reg[NSQRT-1][LW-1:0];
    assign out_side  = side_reg[NSQRT-1];

endmodule

// ===== hw/rtl/qnl_div.sv =====
// Four-lane restoring divider, one quotient bit per pipeline stage.
module qnl_div
    import qnl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [LW-1:0]   in_len,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [CW-1:0]   out_q [NLANE],
    output tag_t            out_tag
);

    logic [NDIV-1:0] v_reg;
    logic [DW-1:0]   d_reg   [NDIV];
    logic [NW-1:0]   rem_reg [NDIV][NLANE];
    logic [CW-1:0]   q_reg   [NDIV][NLANE];
    tag_t            tag_reg [NDIV];
    tag_t            in_tag;

    assign in_tag.neg   = in_side.neg;
    assign in_tag.degen = in_side.degen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NDIV-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < NDIV; j++)
    begin : g_step
        localparam int K = NDIV - 1 - j;
        logic [DW-1:0] d_in;
        logic [NW-1:0] rem_in  [NLANE];
        logic [CW-1:0] q_in    [NLANE];
        logic [NW-1:0] rem_nx  [NLANE];
        logic [CW-1:0] q_nx    [NLANE];
        logic [RW-1:0] trial;

        // Subtract the shifted divisor where it fits.
        always_comb
        begin
            if (j == 0)
            begin
                d_in = {in_len, 1'b0};
            end
            else
            begin
                d_in = d_reg[(j == 0) ? 0 : j - 1];
            end
            trial = RW'(d_in) << K;
            for (int i = 0; i < NLANE; i++)
            begin
                if (j == 0)
                begin
                    rem_in[i] = {in_side.h[i], {CW{1'b0}}} + NW'(in_len);
                    q_in[i]   = '0;
                end
                else
                begin
                    rem_in[i] = rem_reg[(j == 0) ? 0 : j - 1][i];
                    q_in[i]   = q_reg[(j == 0) ? 0 : j - 1][i];
                end
                rem_nx[i] = rem_in[i];
                q_nx[i]   = q_in[i];
                if (RW'(rem_in[i]) >= trial)
                begin
                    rem_nx[i]  = NW'(RW'(rem_in[i]) - trial);
                    q_nx[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j]   <= d_in;
                tag_reg[j] <= (j == 0) ? in_tag : tag_reg[(j == 0) ? 0 : j - 1];
                for (int i = 0; i < NLANE; i++)
                begin
                    rem_reg[j][i] <= rem_nx[i];
                    q_reg[j][i]   <= q_nx[i];
                end
            end
        end
    end

    assign out_valid = v_reg[NDIV-1];
    assign out_q     = q_reg[NDIV-1];
    assign out_tag   = tag_reg[NDIV-1];

endmodule

// ===== hw/rtl/quaternion_nlerp_core.sv =====
// Top level of the shortest-arc normalized quaternion blend pipeline.
//
//  Channel  Direction  Ports                 Contents
//  s_*      in         tvalid tready tdata   two quaternions and blend factor
//  m_*      out        tvalid tready tdata   normalized quaternion
//                      tuser                 degenerate flag
//
// One item enters per cycle while the output is not stalled. The pipeline holds 6 front
// stages, 32 square root stages, 16 divider stages and the output register.
// The square root and divider pipelines, one bit per stage, set that depth.
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output holds every stage in place, so nothing is lost or repeated.
module quaternion_nlerp_core
    import qnl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, aw, bx, by, bz, bw (16 bits each), blend (17 bits), zero pad
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rx, ry, rz, rw (16 bits each)
    output logic [63:0]  m_tdata,
    // degenerate
    output logic [0:0]   m_tuser
);

    logic                 en;
    logic signed [CW-1:0] a [NLANE];
    logic signed [CW-1:0] b [NLANE];
    logic                 f_valid;
    side_t                f_side;
    logic [SW-1:0]        f_s;
    logic                 q_valid;
    logic [LW-1:0]        q_len;
    side_t                q_side;
    logic                 d_valid;
    logic [CW-1:0]        d_q [NLANE];
    tag_t                 d_tag;
    logic [CW-1:0]        r_next [NLANE];
    logic                 m_valid_reg;
    logic [63:0]          m_data_reg;
    logic                 m_degen_reg;

    // The whole pipeline advances unless a held result is stalled.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            a[i] = s_tdata[i*CW +: CW];
            b[i] = s_tdata[(i+NLANE)*CW +: CW];
        end
    end

    qnl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .a         (a),
        .b         (b),
        .t         (s_tdata[2*NLANE*CW +: TW]),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_s     (f_s)
    );

    qnl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_s      (f_s),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_len   (q_len),
        .out_side  (q_side)
    );

    qnl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_len    (q_len),
        .in_side   (q_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_tag   (d_tag)
    );

    // Apply signs, saturate, and substitute the identity for a zero blend.
    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            if (d_tag.neg[i])
            begin
                r_next[i] = (d_q[i] > MAX_NEG) ? MAX_NEG : d_q[i];
                r_next[i] = ~r_next[i] + 1'b1;
            end
            else
            begin
                r_next[i] = (d_q[i] > MAX_POS) ? MAX_POS : d_q[i];
            end
            if (d_tag.degen)
            begin
                r_next[i] = (i == NLANE - 1) ? MAX_POS : '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg  <= {r_next[3], r_next[2], r_next[1], r_next[0]};
            m_degen_reg <= d_tag.degen;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_degen_reg;

    // A degenerate result is always the identity.
    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == {MAX_POS, 48'd0}))
        else $error("degenerate result is not the identity");

    // The input side stalls exactly when a held result is not taken.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    // A stalled output keeps its item through the next edge.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Lanes 0 and 3 of a non-degenerate quotient never exceed one in Q1.15.
    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid && !d_tag.degen) |-> (d_q[0] <= MAX_NEG && d_q[3] <= MAX_NEG))
        else $error("divider quotient out of range");

endmodule
